// ----- hw/rtl/decision_tree_inference_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef DECISION_TREE_INFERENCE_ASSERT_SVH
`define DECISION_TREE_INFERENCE_ASSERT_SVH

// Same-cycle implication.
`define DTI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dti assertion failed");

// Next-cycle implication.
`define DTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dti assertion failed");

`endif

// ----- hw/rtl/dti_pkg.sv -----
`default_nettype none
package dti_pkg;
   localparam int NODE_SLOTS = 128;
   localparam int NODE_AW    = $clog2(NODE_SLOTS);
   localparam int FEAT_COUNT = 64;
   localparam int FEAT_AW    = $clog2(FEAT_COUNT);
   localparam int FEAT_SEL_W = 6;
   localparam int MAX_DEPTH  = 6;
   localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
   localparam int LIMIT_W    = 3;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd6;

   localparam logic ACT_NODE    = 1'b0;
   localparam logic ACT_FEATURE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNWRITTEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEPTH     = 2'd2;

   typedef struct packed {
      logic                     leaf;
      logic [FEAT_SEL_W-1:0]    split;
      logic signed [DATA_W-1:0] threshold;
      logic signed [DATA_W-1:0] leaf_value;
   } node_type;

   typedef struct packed {
      logic               en;
      logic [NODE_AW-1:0] addr;
      node_type           data;
   } node_wr_type;

   typedef struct packed {
      logic                     en;
      logic [FEAT_AW-1:0]       addr;
      logic signed [DATA_W-1:0] data;
   } feat_wr_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prediction;
      logic [NODE_AW-1:0]       leaf_node;
      logic [STATUS_W-1:0]      status;
   } result_type;
endpackage
`default_nettype wire

// ----- hw/rtl/dti_req_if.sv -----
`default_nettype none
interface dti_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [6:0]  node_index;
   logic        node_is_leaf;
   logic [5:0]  split_feature;
   logic signed [31:0] threshold;
   logic signed [31:0] leaf_value;
   logic [5:0]  feature_slot;
   logic signed [31:0] feature_value;
   logic        last_feature;

   modport source (
      output valid, action, node_index, node_is_leaf, split_feature, threshold,
             leaf_value, feature_slot, feature_value, last_feature,
      input  ready
   );
   modport sink (
      input  valid, action, node_index, node_is_leaf, split_feature, threshold,
             leaf_value, feature_slot, feature_value, last_feature,
      output ready
   );
endinterface
`default_nettype wire

// ----- hw/rtl/dti_rsp_if.sv -----
`default_nettype none
interface dti_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] prediction;
   logic [6:0]  leaf_node;
   logic [1:0]  status;

   modport source (output valid, prediction, leaf_node, status, input ready);
   modport sink (input valid, prediction, leaf_node, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dti_node_mem.sv -----
`default_nettype none
module dti_node_mem import dti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  node_wr_type        wr,
   input  logic               rd_en,
   input  logic [NODE_AW-1:0] rd_addr,
   output node_type           rd_data,
   output logic               rd_valid
);
   node_type                mem_ram [NODE_SLOTS];
   logic [NODE_SLOTS-1:0]   valid_ff;
   node_type                rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ram[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ram[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/dti_feat_mem.sv -----
`default_nettype none
module dti_feat_mem import dti_pkg::*; (
   input  logic                     clock,
   input  feat_wr_type              wr,
   input  logic                     rd_en,
   input  logic [FEAT_AW-1:0]       rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);
   logic signed [DATA_W-1:0] mem_ram [FEAT_COUNT];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ram[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/dti_walker.sv -----
`default_nettype none
module dti_walker import dti_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   dti_req_if.sink                  req_chan,
   dti_rsp_if.source                rsp_chan,
   input  logic [DEPTH_W-1:0]       eff_limit,
   output node_wr_type              node_wr,
   output logic                     node_rd_en,
   output logic [NODE_AW-1:0]       node_rd_addr,
   input  node_type                 node_rd_data,
   input  logic                     node_rd_valid,
   output feat_wr_type              feat_wr,
   output logic                     feat_rd_en,
   output logic [FEAT_AW-1:0]       feat_rd_addr,
   input  logic signed [DATA_W-1:0] feat_rd_data
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NODE = 2'd1;
   localparam logic [1:0] S_FEAT = 2'd2;
   localparam logic [1:0] S_PUT  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [NODE_AW-1:0]       node_ff, node_in;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic signed [DATA_W-1:0] thr_ff, thr_in;
   logic                     feat_ok_ff, feat_ok_in;
   result_type               res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic signed [DATA_W-1:0] feat_val;
   logic                     go_left;
   logic [NODE_AW+1:0]       child;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign node_wr.en              = accept && (req_chan.action == ACT_NODE);
   assign node_wr.addr            = req_chan.node_index;
   assign node_wr.data.leaf       = req_chan.node_is_leaf;
   assign node_wr.data.split      = req_chan.split_feature;
   assign node_wr.data.threshold  = req_chan.threshold;
   assign node_wr.data.leaf_value = req_chan.leaf_value;

   assign feat_wr.en   = accept && (req_chan.action == ACT_FEATURE)
                         && (int'(req_chan.feature_slot) < FEAT_COUNT);
   assign feat_wr.addr = req_chan.feature_slot[FEAT_AW-1:0];
   assign feat_wr.data = req_chan.feature_value;

   assign feat_val = feat_ok_ff ? feat_rd_data : '0;
   assign go_left  = (feat_val <= thr_ff);
   assign child    = {1'b0, node_ff, 1'b0} + (NODE_AW+2)'({!go_left, go_left});

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      thr_in       = thr_ff;
      feat_ok_in   = feat_ok_ff;
      res_in       = res_ff;
      node_rd_en   = 1'b0;
      node_rd_addr = node_ff;
      feat_rd_en   = 1'b0;
      feat_rd_addr = node_rd_data.split[FEAT_AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_chan.action == ACT_FEATURE) && req_chan.last_feature) begin
               node_in      = '0;
               depth_in     = '0;
               node_rd_en   = 1'b1;
               node_rd_addr = '0;
               state_in     = S_NODE;
            end
         end
         S_NODE: begin
            res_in.leaf_node  = node_ff;
            res_in.prediction = '0;
            if (!node_rd_valid) begin
               res_in.status = STATUS_UNWRITTEN;
               state_in      = S_PUT;
            end else if (node_rd_data.leaf) begin
               res_in.status     = STATUS_OK;
               res_in.prediction = node_rd_data.leaf_value;
               state_in          = S_PUT;
            end else if (depth_ff >= eff_limit) begin
               res_in.status = STATUS_DEPTH;
               state_in      = S_PUT;
            end else begin
               feat_rd_en = 1'b1;
               thr_in     = node_rd_data.threshold;
               feat_ok_in = (int'(node_rd_data.split) < FEAT_COUNT);
               state_in   = S_FEAT;
            end
         end
         S_FEAT: begin
            if (child[NODE_AW+1:NODE_AW] != 2'b00) begin
               res_in.leaf_node  = node_ff;
               res_in.prediction = '0;
               res_in.status     = STATUS_UNWRITTEN;
               state_in          = S_PUT;
            end else begin
               node_in      = child[NODE_AW-1:0];
               depth_in     = DEPTH_W'(depth_ff + 1'b1);
               node_rd_en   = 1'b1;
               node_rd_addr = child[NODE_AW-1:0];
               state_in     = S_NODE;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      thr_ff      <= thr_in;
      feat_ok_ff  <= feat_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prediction = rsp_data_ff.prediction;
   assign rsp_chan.leaf_node  = rsp_data_ff.leaf_node;
   assign rsp_chan.status     = rsp_data_ff.status;
endmodule
`default_nettype wire

// ----- hw/rtl/decision_tree_inference.sv -----
// Decision tree inference over a 128-node implicit binary tree (children of node i at
// 2i+1 and 2i+2) held in an on-chip node memory, with sample features held in a 64-entry
// feature memory. A node write or a feature load returns nothing; a feature beat with
// last_feature set starts a walk from the root and blocks the request channel until the
// walk's beat is placed in the output register. Each level that a walk descends costs one
// node-memory read and one dependent feature-memory read, both registered. Node valid
// bits clear at reset with no sweep; feature and node contents are undefined until
// written. Values are Q16.16 signed, compared without rounding.
// Write csr_wr_data only while idle.
`default_nettype none
module decision_tree_inference import dti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dti_req_if.sink            req_chan,
   dti_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);
   logic [LIMIT_W-1:0]       depth_limit_ff;
   logic [DEPTH_W-1:0]       eff_limit;
   node_wr_type              node_wr;
   logic                     node_rd_en;
   logic [NODE_AW-1:0]       node_rd_addr;
   node_type                 node_rd_data;
   logic                     node_rd_valid;
   feat_wr_type              feat_wr;
   logic                     feat_rd_en;
   logic [FEAT_AW-1:0]       feat_rd_addr;
   logic signed [DATA_W-1:0] feat_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         depth_limit_ff <= csr_wr_data;
      end
   end

   assign eff_limit = (int'(depth_limit_ff) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                          : DEPTH_W'(depth_limit_ff);

   dti_node_mem u_node_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (node_wr),
      .rd_en    (node_rd_en),
      .rd_addr  (node_rd_addr),
      .rd_data  (node_rd_data),
      .rd_valid (node_rd_valid)
   );

   dti_feat_mem u_feat_mem (
      .clock   (clock),
      .wr      (feat_wr),
      .rd_en   (feat_rd_en),
      .rd_addr (feat_rd_addr),
      .rd_data (feat_rd_data)
   );

   dti_walker u_walker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .eff_limit     (eff_limit),
      .node_wr       (node_wr),
      .node_rd_en    (node_rd_en),
      .node_rd_addr  (node_rd_addr),
      .node_rd_data  (node_rd_data),
      .node_rd_valid (node_rd_valid),
      .feat_wr       (feat_wr),
      .feat_rd_en    (feat_rd_en),
      .feat_rd_addr  (feat_rd_addr),
      .feat_rd_data  (feat_rd_data)
   );
endmodule
`default_nettype wire

// ----- hw/rtl/dti_checker.sv -----
`default_nettype none
`include "decision_tree_inference_assert.svh"
module dti_checker import dti_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_action,
   input wire logic                     req_last_feature,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_prediction,
   input wire logic [STATUS_W-1:0]      rsp_status
);
   `DTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `DTI_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), rsp_prediction == '0)
   `DTI_ASSERT_NEXT(a_walk_busy, clock, reset, req_valid && req_ready && (req_action == ACT_FEATURE) && req_last_feature, !req_ready)
   `DTI_ASSERT_IMPLY(a_rsp_from_walk, clock, reset, $rose(rsp_valid), $past(!req_ready))
endmodule

bind decision_tree_inference dti_checker u_dti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_action       (req_chan.action),
   .req_last_feature (req_chan.last_feature),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_prediction   (rsp_chan.prediction),
   .rsp_status       (rsp_chan.status)
);
`default_nettype wire

// ----- sim/decision_tree_inference_tb.sv -----
`default_nettype none
module decision_tree_inference_tb import dti_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned IDLE_PERCENT  = 24;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct {
      logic                     action;
      logic [NODE_AW-1:0]       node_index;
      logic                     node_is_leaf;
      logic [FEAT_SEL_W-1:0]    split_feature;
      logic signed [DATA_W-1:0] threshold;
      logic signed [DATA_W-1:0] leaf_value;
      logic [FEAT_AW-1:0]       feature_slot;
      logic signed [DATA_W-1:0] feature_value;
      logic                     last_feature;
   } tree_cmd_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   dti_req_if req_bus();
   dti_rsp_if rsp_bus();

   decision_tree_inference dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bit                       tree_valid [NODE_SLOTS];
   node_type                 tree_mem [NODE_SLOTS];
   logic signed [DATA_W-1:0] feat_mem [FEAT_COUNT];
   logic [LIMIT_W-1:0]       depth_cap = LIMIT_RESET;
   result_type               pending_results [$];

   int unsigned fail_count = 0;
   int unsigned sent_count = 0;
   int unsigned holds_asked = 0;
   bit          steady = 1'b0;
   bit          features_primed = 1'b0;

   always #1 clock = ~clock;

   function automatic result_type walk_tree();
      result_type  r;
      int unsigned node;
      int unsigned depth;
      int unsigned lim;
      int unsigned child;
      bit          done;
      r = '0;
      r.status = STATUS_OK;
      node = 0;
      depth = 0;
      done = 1'b0;
      lim = (depth_cap > MAX_DEPTH) ? MAX_DEPTH : depth_cap;
      while (!done) begin
         if (!tree_valid[node]) begin
            r.status = STATUS_UNWRITTEN;
            done = 1'b1;
         end else if (tree_mem[node].leaf) begin
            r.prediction = tree_mem[node].leaf_value;
            done = 1'b1;
         end else if (depth >= lim) begin
            r.status = STATUS_DEPTH;
            done = 1'b1;
         end else begin
            if ($signed(feat_mem[tree_mem[node].split]) <= $signed(tree_mem[node].threshold))
               child = 2 * node + 1;
            else
               child = 2 * node + 2;
            if (child >= NODE_SLOTS) begin
               r.status = STATUS_UNWRITTEN;
               done = 1'b1;
            end else begin
               node = child;
               depth++;
            end
         end
      end
      r.leaf_node = node[NODE_AW-1:0];
      return r;
   endfunction

   function automatic void absorb(input tree_cmd_type c);
      if (c.action == ACT_NODE) begin
         tree_valid[c.node_index] = 1'b1;
         tree_mem[c.node_index].leaf = c.node_is_leaf;
         tree_mem[c.node_index].split = c.split_feature;
         tree_mem[c.node_index].threshold = c.threshold;
         tree_mem[c.node_index].leaf_value = c.leaf_value;
      end else begin
         feat_mem[c.feature_slot] = c.feature_value;
         if (c.last_feature)
            pending_results = {pending_results, walk_tree()};
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2, 3: return $urandom;
         default: return (int'($urandom_range(0, 16)) - 8) * 65536
                         + int'($urandom_range(0, 3)) * 16384;
      endcase
   endfunction

   function automatic tree_cmd_type node_cmd(input logic [NODE_AW-1:0] idx, input logic leaf,
                                             input logic [FEAT_SEL_W-1:0] split,
                                             input logic signed [DATA_W-1:0] thr,
                                             input logic signed [DATA_W-1:0] val);
      tree_cmd_type c;
      c.action = ACT_NODE;
      c.node_index = idx;
      c.node_is_leaf = leaf;
      c.split_feature = split;
      c.threshold = thr;
      c.leaf_value = val;
      c.feature_slot = FEAT_AW'($urandom);
      c.feature_value = $urandom;
      c.last_feature = 1'($urandom);
      return c;
   endfunction

   function automatic tree_cmd_type feat_cmd(input logic [FEAT_AW-1:0] slot,
                                             input logic signed [DATA_W-1:0] val,
                                             input logic last);
      tree_cmd_type c;
      c.action = ACT_FEATURE;
      c.node_index = NODE_AW'($urandom);
      c.node_is_leaf = 1'($urandom);
      c.split_feature = FEAT_SEL_W'($urandom);
      c.threshold = $urandom;
      c.leaf_value = $urandom;
      c.feature_slot = slot;
      c.feature_value = val;
      c.last_feature = last;
      return c;
   endfunction

   task automatic issue(input tree_cmd_type c);
      @(negedge clock);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= c.action;
      req_bus.node_index <= c.node_index;
      req_bus.node_is_leaf <= c.node_is_leaf;
      req_bus.split_feature <= c.split_feature;
      req_bus.threshold <= c.threshold;
      req_bus.leaf_value <= c.leaf_value;
      req_bus.feature_slot <= c.feature_slot;
      req_bus.feature_value <= c.feature_value;
      req_bus.last_feature <= c.last_feature;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb(c);
      sent_count++;
   endtask

   task automatic reconfigure(input logic [LIMIT_W-1:0] lim);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      depth_cap = lim;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_sample(input bit full);
      int unsigned count;
      if (full) begin
         for (int unsigned s = 0; s < FEAT_COUNT; s++)
            issue(feat_cmd(FEAT_AW'(s), pick_value(), s == FEAT_COUNT - 1));
         features_primed = 1'b1;
      end else begin
         count = $urandom_range(1, 6);
         for (int unsigned i = 1; i <= count; i++)
            issue(feat_cmd(FEAT_AW'($urandom), pick_value(), i == count));
      end
   endtask

   task automatic grow_tree();
      int unsigned span;
      int unsigned last_node;
      int unsigned lvl;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      last_node = (2 << span) - 2;
      for (int unsigned n = 0; n <= last_node; n++) begin
         lvl = $clog2(n + 2) - 1;
         if ($urandom_range(0, 19) != 0)
            issue(node_cmd(NODE_AW'(n), lvl == span || $urandom_range(0, 4) == 0,
                           FEAT_SEL_W'($urandom), pick_value(), pick_value()));
      end
   endtask

   task automatic poke_nodes();
      repeat ($urandom_range(1, 3))
         issue(node_cmd(NODE_AW'($urandom), 1'($urandom), FEAT_SEL_W'($urandom),
                        $urandom, $urandom));
   endtask

   task automatic test_empty_tree();
      issue(feat_cmd(FEAT_AW'(0), Q_MAX, 1'b0));
      issue(feat_cmd(FEAT_AW'(FEAT_COUNT - 1), Q_MIN, 1'b0));
      issue(feat_cmd(FEAT_AW'(1), 0, 1'b1));
   endtask

   task automatic test_split_compare();
      issue(node_cmd(NODE_AW'(0), 1'b0, FEAT_SEL_W'(0), Q_MAX, $urandom));
      issue(node_cmd(NODE_AW'(1), 1'b1, FEAT_SEL_W'($urandom), $urandom, Q_MIN));
      issue(feat_cmd(FEAT_AW'(2), pick_value(), 1'b1));
      issue(node_cmd(NODE_AW'(0), 1'b0, FEAT_SEL_W'(FEAT_COUNT - 1), Q_MIN, $urandom));
      issue(feat_cmd(FEAT_AW'(3), pick_value(), 1'b1));
      issue(node_cmd(NODE_AW'(0), 1'b0, FEAT_SEL_W'(0), Q_MAX - 1, $urandom));
      issue(feat_cmd(FEAT_AW'(4), pick_value(), 1'b1));
      issue(node_cmd(NODE_AW'(2), 1'b1, FEAT_SEL_W'($urandom), $urandom, Q_MAX));
      issue(feat_cmd(FEAT_AW'(5), pick_value(), 1'b1));
      issue(node_cmd(NODE_AW'(0), 1'b1, FEAT_SEL_W'($urandom), $urandom, 0));
      issue(feat_cmd(FEAT_AW'(6), pick_value(), 1'b1));
   endtask

   task automatic test_depth_limit();
      int unsigned n;
      n = 0;
      while (n < NODE_SLOTS - 1) begin
         issue(node_cmd(NODE_AW'(n), 1'b0, FEAT_SEL_W'(FEAT_COUNT - 1), Q_MIN, $urandom));
         n = 2 * n + 1;
      end
      issue(node_cmd(NODE_AW'(NODE_SLOTS - 1), 1'b1, FEAT_SEL_W'($urandom), $urandom, Q_MAX));
      reconfigure(3'd7);
      issue(feat_cmd(FEAT_AW'(7), pick_value(), 1'b1));
      reconfigure(3'd0);
      issue(feat_cmd(FEAT_AW'(8), pick_value(), 1'b1));
      reconfigure(3'd3);
      issue(feat_cmd(FEAT_AW'(9), pick_value(), 1'b1));
      issue(node_cmd(NODE_AW'(NODE_SLOTS / 2 - 1), 1'b1, FEAT_SEL_W'(0), 0, Q_MIN));
      reconfigure(3'd6);
      issue(feat_cmd(FEAT_AW'(10), pick_value(), 1'b1));
   endtask

   task automatic test_random_trees(input int unsigned budget);
      int unsigned stop_at;
      stop_at = sent_count + budget;
      if (!features_primed)
         random_sample(1'b1);
      while (sent_count < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1: grow_tree();
            2, 3: poke_nodes();
            4: reconfigure($urandom_range(0, 1) ? LIMIT_W'($urandom_range(6, 7))
                                                : LIMIT_W'($urandom_range(0, 5)));
            default: random_sample(1'b0);
         endcase
      end
   endtask

   task automatic test_result_backlog();
      holds_asked++;
      repeat (12)
         issue(feat_cmd(FEAT_AW'($urandom), pick_value(), 1'b1));
      repeat (4)
         random_sample(1'b0);
   endtask

   task automatic test_no_idle(input int unsigned budget);
      steady = 1'b1;
      test_random_trees(budget);
      steady = 1'b0;
   endtask

   initial begin : rsp_drain
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected beat: prediction %h leaf_node %0d status %0d",
                        rsp_bus.prediction, rsp_bus.leaf_node, rsp_bus.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.prediction !== want.prediction || rsp_bus.leaf_node !== want.leaf_node
                || rsp_bus.status !== want.status) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                           want.prediction, want.leaf_node, want.status,
                           rsp_bus.prediction, rsp_bus.leaf_node, rsp_bus.status);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_NODE;
      req_bus.node_index = '0;
      req_bus.node_is_leaf = 1'b0;
      req_bus.split_feature = '0;
      req_bus.threshold = '0;
      req_bus.leaf_value = '0;
      req_bus.feature_slot = '0;
      req_bus.feature_value = '0;
      req_bus.last_feature = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_tree();
      test_split_compare();
      test_depth_limit();
      test_random_trees(900);
      test_result_backlog();
      test_no_idle(300);
      test_random_trees(800);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
